/* hdl/dwc_pkg.sv */
// ----------------------------------------------------------------------------
// dwc_pkg
// Types and constants shared by the delay window controller.
// ----------------------------------------------------------------------------
package dwc_pkg;

  localparam int SEQ_W    = 32;
  localparam int TIME_W   = 32;
  localparam int WIN_W    = 32;
  localparam int OUTST_W  = 9;
  localparam int DELAY_W  = 16;
  localparam int STEP_W   = 8;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  // entry layout: valid | seq | send time
  localparam int ENT_W    = 1 + SEQ_W + TIME_W;

  localparam logic [WIN_W-1:0]   WINDOW_RESET = 32'd100;
  localparam logic [WIN_W-1:0]   WINDOW_MAX   = 32'hFFFF_FFFF;
  localparam logic [DELAY_W-1:0] LOW_RESET    = 16'd20;
  localparam logic [DELAY_W-1:0] HIGH_RESET   = 16'd100;
  localparam logic [STEP_W-1:0]  INC_RESET    = 8'd1;
  localparam logic [STEP_W-1:0]  DEC_RESET    = 8'd5;

  localparam logic MODE_SEND = 1'b0;
  localparam logic MODE_ACK  = 1'b1;

  typedef enum logic [1:0] {
    REG_LOW_DELAY  = 2'd0,
    REG_HIGH_DELAY = 2'd1,
    REG_INC_STEP   = 2'd2,
    REG_DEC_STEP   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DELAY_W-1:0] low_delay;
    logic [DELAY_W-1:0] high_delay;
    logic [STEP_W-1:0]  inc_step;
    logic [STEP_W-1:0]  dec_step;
  } cfg_t;

endpackage

/* hdl/dwc_in_if.sv */
// ----------------------------------------------------------------------------
// dwc_in_if
// Event channel: one word per send or ack event.
// ----------------------------------------------------------------------------
interface dwc_in_if import dwc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SEQ_W-1:0]  seq_num;
  logic [TIME_W-1:0] sent_at_ms;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, mode, seq_num, sent_at_ms, now_ms, input ready);
  modport sink   (input valid, mode, seq_num, sent_at_ms, now_ms, output ready);
endinterface

/* hdl/dwc_out_if.sv */
// ----------------------------------------------------------------------------
// dwc_out_if
// Result channel: one word per event.
// ----------------------------------------------------------------------------
interface dwc_out_if import dwc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WIN_W-1:0]   window_datagrams;
  logic               table_full;
  logic [OUTST_W-1:0] outstanding;

  modport source (output valid, window_datagrams, table_full, outstanding, input ready);
  modport sink   (input valid, window_datagrams, table_full, outstanding, output ready);
endinterface

/* hdl/dwc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dwc_cfg_regs
// APB register bank: delay thresholds and window steps.
// ----------------------------------------------------------------------------
module dwc_cfg_regs import dwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_delay  <= LOW_RESET;
      cfg_q.high_delay <= HIGH_RESET;
      cfg_q.inc_step   <= INC_RESET;
      cfg_q.dec_step   <= DEC_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_LOW_DELAY:  cfg_q.low_delay  <= pwdata[DELAY_W-1:0];
        REG_HIGH_DELAY: cfg_q.high_delay <= pwdata[DELAY_W-1:0];
        REG_INC_STEP:   cfg_q.inc_step   <= pwdata[STEP_W-1:0];
        REG_DEC_STEP:   cfg_q.dec_step   <= pwdata[STEP_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOW_DELAY:  prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg_q.low_delay};
      REG_HIGH_DELAY: prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg_q.high_delay};
      REG_INC_STEP:   prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_q.inc_step};
      REG_DEC_STEP:   prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_q.dec_step};
    endcase
  end

endmodule

/* hdl/dwc_entry_mem.sv */
// ----------------------------------------------------------------------------
// dwc_entry_mem
// Outstanding-entry table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dwc_entry_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

endmodule

/* hdl/dwc_scan_ctrl.sv */
// ----------------------------------------------------------------------------
// dwc_scan_ctrl
// Per-event table sweep: drop entries holding the event's sequence number, find
// a free slot, check ages, update the window and hold the result word.
// ----------------------------------------------------------------------------
module dwc_scan_ctrl import dwc_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cfg_t                           cfg_i,
  dwc_in_if.sink                         in_i,
  dwc_out_if.source                      out_o,
  output logic                           mem_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr_o,
  output logic [ENT_W-1:0]               mem_wdata_o,
  output logic                           mem_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr_o,
  input  logic [ENT_W-1:0]               mem_rdata_i
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               mode_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [TIME_W-1:0]  sent_q;
  logic [TIME_W-1:0]  now_q;
  logic               free_found_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic               grow_q;
  logic               shrink_q;
  logic               new_grow_q;
  logic               new_shrink_q;
  logic [CNT_W-1:0]   count_q;
  logic [WIN_W-1:0]   window_q;
  logic               full_q;
  logic               out_valid_q;
  logic [WIN_W-1:0]   out_window_q;
  logic               out_full_q;
  logic [OUTST_W-1:0] out_outst_q;

  logic               scan_rd;
  logic               rd_valid;
  logic               rd_match;
  logic               rd_keep;
  logic [TIME_W-1:0]  rd_age;
  logic [TIME_W-1:0]  new_age;
  logic [TIME_W-1:0]  low_ext;
  logic [TIME_W-1:0]  high_ext;
  logic               is_send;
  logic               do_store;
  logic               shrink_all;
  logic               grow_all;
  logic [WIN_W:0]     grow_sum;
  logic [WIN_W-1:0]   win_grown;
  logic [WIN_W-1:0]   win_shrunk;
  logic [WIN_W-1:0]   win_next;
  logic [CNT_W+OUTST_W-1:0] count_ext;

  assign scan_rd  = (state_q == ST_SCAN) && (cnt_q != CNT_W'(TABLE_DEPTH));
  assign rd_valid = mem_rdata_i[ENT_W-1];
  assign rd_match = rd_valid && (mem_rdata_i[SEQ_W+TIME_W-1:TIME_W] == seq_q);
  assign rd_keep  = rd_valid && !rd_match;
  assign rd_age   = now_q - mem_rdata_i[TIME_W-1:0];
  assign new_age  = now_q - sent_q;
  assign low_ext  = {{(TIME_W-DELAY_W){1'b0}}, cfg_i.low_delay};
  assign high_ext = {{(TIME_W-DELAY_W){1'b0}}, cfg_i.high_delay};
  assign is_send  = (mode_q == MODE_SEND);
  assign do_store = is_send && free_found_q;

  assign shrink_all = shrink_q || (do_store && new_shrink_q);
  assign grow_all   = grow_q || (do_store && new_grow_q);
  assign grow_sum   = {1'b0, window_q} + {{(WIN_W+1-STEP_W){1'b0}}, cfg_i.inc_step};
  assign win_grown  = grow_sum[WIN_W] ? WINDOW_MAX : grow_sum[WIN_W-1:0];
  assign win_shrunk = (window_q < {{(WIN_W-STEP_W){1'b0}}, cfg_i.dec_step}) ? '0 :
                      window_q - {{(WIN_W-STEP_W){1'b0}}, cfg_i.dec_step};
  assign count_ext  = {{OUTST_W{1'b0}}, count_q};

  always_comb begin
    if (!is_send) begin
      win_next = win_grown;
    end else if (shrink_all) begin
      win_next = win_shrunk;
    end else if (grow_all) begin
      win_next = win_grown;
    end else begin
      win_next = window_q;
    end
  end

  assign mem_re_o    = scan_rd;
  assign mem_raddr_o = cnt_q[IDX_W-1:0];

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[IDX_W-1:0];
    mem_wdata_o = '0;
    priority if (state_q == ST_CLEAR) begin
      mem_we_o = 1'b1;
    end else if (state_q == ST_SCAN && rd_vld_q && rd_match) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = rd_idx_q;
      mem_wdata_o = {1'b0, mem_rdata_i[ENT_W-2:0]};
    end else if (state_q == ST_FINISH && do_store) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = free_idx_q;
      mem_wdata_o = {1'b1, seq_q, sent_q};
    end
  end

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.window_datagrams = out_window_q;
  assign out_o.table_full       = out_full_q;
  assign out_o.outstanding      = out_outst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      mode_q       <= MODE_SEND;
      seq_q        <= '0;
      sent_q       <= '0;
      now_q        <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      grow_q       <= 1'b0;
      shrink_q     <= 1'b0;
      new_grow_q   <= 1'b0;
      new_shrink_q <= 1'b0;
      count_q      <= '0;
      window_q     <= WINDOW_RESET;
      full_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_window_q <= '0;
      out_full_q   <= 1'b0;
      out_outst_q  <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (cnt_q == CNT_W'(TABLE_DEPTH - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_i.valid) begin
            mode_q       <= in_i.mode;
            seq_q        <= in_i.seq_num;
            sent_q       <= in_i.sent_at_ms;
            now_q        <= in_i.now_ms;
            cnt_q        <= '0;
            rd_vld_q     <= 1'b0;
            free_found_q <= 1'b0;
            grow_q       <= 1'b0;
            shrink_q     <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_vld_q     <= scan_rd;
          rd_idx_q     <= cnt_q[IDX_W-1:0];
          new_grow_q   <= (new_age <= low_ext);
          new_shrink_q <= (new_age >= high_ext);
          if (scan_rd) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (rd_vld_q) begin
            if (rd_match) begin
              count_q <= count_q - 1'b1;
            end
            if (!rd_keep && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= rd_idx_q;
            end
            if (rd_keep && is_send) begin
              if (rd_age <= low_ext) grow_q <= 1'b1;
              if (rd_age >= high_ext) shrink_q <= 1'b1;
            end
          end
          if (!scan_rd && !rd_vld_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          window_q <= win_next;
          full_q   <= is_send && !free_found_q;
          if (do_store) begin
            count_q <= count_q + 1'b1;
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_window_q <= window_q;
            out_full_q   <= full_q;
            out_outst_q  <= count_ext[OUTST_W-1:0];
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/delay_window_controller.sv */
// ----------------------------------------------------------------------------
// delay_window_controller
// Sender-side congestion window controller driven by datagram delay.
//
// Events (send or ack) arrive as words on in_i; each event gives exactly one
// result word on out_o with the window, a table-full flag and the number of
// outstanding entries. Thresholds and steps sit in an APB register bank at
// byte addresses 0, 4, 8 and 12; write them only while the block is idle.
// Every event sweeps the whole entry table through its single read port, one
// entry per cycle; one event is worked on at a time. in_i.ready is high
// whenever the sweep engine is idle, even while a result word waits on out_o.
// After reset the table is cleared, one entry per cycle, during which no event
// is accepted; registers may be written. The window resets to 100. When the
// receiver stalls, the finished result is held on out_o; the next event may be
// accepted and swept, and its result waits until the held word is taken.
// ----------------------------------------------------------------------------
module delay_window_controller import dwc_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  dwc_in_if.sink            in_i,
  dwc_out_if.source         out_o
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  cfg_t             cfg;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [ENT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENT_W-1:0] mem_rdata;

  dwc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dwc_entry_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENT_W)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dwc_scan_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_scan_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  a_outst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && TABLE_DEPTH <= 511) |-> (out_o.outstanding <= 9'(TABLE_DEPTH)))
    else $error("outstanding count above table depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.table_full) |-> (out_o.outstanding == 9'(TABLE_DEPTH)))
    else $error("table full flagged with free entries");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("event accepted while sweep in progress");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delay window controller. A model of the
// entry table, window and thresholds predicts every result word; the result
// channel is checked field by field. Directed events cover the age edges and
// time wrap, then the window floor, a full table, and random send/ack
// traffic under several threshold settings with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import dwc_pkg::*;

  localparam int TABLE_DEPTH  = 256;
  localparam int LIMIT_CYCLES = 3_000_000;

  typedef struct packed {
    logic [WIN_W-1:0]   window;
    logic               full;
    logic [OUTST_W-1:0] outstanding;
  } window_word_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dwc_in_if  ev_bus ();
  dwc_out_if res_bus ();

  delay_window_controller #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (ev_bus),
    .out_o   (res_bus)
  );

  // table and window model
  logic [SEQ_W-1:0]  held_seq  [TABLE_DEPTH];
  logic [TIME_W-1:0] held_sent [TABLE_DEPTH];
  bit                held_live [TABLE_DEPTH];
  int unsigned       held_count;
  logic [WIN_W-1:0]  win_model;
  cfg_t              cfg_model;

  window_word_t      pending_words[$];
  int unsigned       err_count;
  longint unsigned   cycle_count;
  bit                sender_idle_en;
  bit                receiver_stall_en;
  logic [TIME_W-1:0] now_base;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    err_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic void grow_window();
    logic [WIN_W:0] sum;
    sum = {1'b0, win_model} + cfg_model.inc_step;
    win_model = sum[WIN_W] ? WINDOW_MAX : sum[WIN_W-1:0];
  endfunction

  function automatic void shrink_window();
    if (win_model < cfg_model.dec_step) win_model = '0;
    else win_model = win_model - cfg_model.dec_step;
  endfunction

  function automatic window_word_t predict_event(logic mode, logic [SEQ_W-1:0] seq,
                                                 logic [TIME_W-1:0] sent,
                                                 logic [TIME_W-1:0] now);
    window_word_t w;
    bit stored;
    bit grow;
    bit shrink;
    logic [TIME_W-1:0] age;
    stored = 1'b0;
    grow   = 1'b0;
    shrink = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (held_live[i] && held_seq[i] == seq) begin
        held_live[i] = 1'b0;
        held_count--;
      end
    end
    if (mode == MODE_SEND) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!stored && !held_live[i]) begin
          held_seq[i]  = seq;
          held_sent[i] = sent;
          held_live[i] = 1'b1;
          held_count++;
          stored = 1'b1;
        end
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (held_live[i]) begin
          age = now - held_sent[i];
          if (age <= cfg_model.low_delay) grow = 1'b1;
          if (age >= cfg_model.high_delay) shrink = 1'b1;
        end
      end
      if (shrink) shrink_window();
      else if (grow) grow_window();
    end else begin
      grow_window();
    end
    w.window      = win_model;
    w.full        = (mode == MODE_SEND) && !stored;
    w.outstanding = held_count[OUTST_W-1:0];
    return w;
  endfunction

  function automatic logic [SEQ_W-1:0] pick_live_seq();
    int start;
    int idx;
    start = $urandom_range(0, TABLE_DEPTH - 1);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      idx = (start + k) % TABLE_DEPTH;
      if (held_live[idx]) return held_seq[idx];
    end
    return $urandom;
  endfunction

  task automatic send_event(logic mode, logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] sent,
                            logic [TIME_W-1:0] now);
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      ev_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    ev_bus.valid      <= 1'b1;
    ev_bus.mode       <= mode;
    ev_bus.seq_num    <= seq;
    ev_bus.sent_at_ms <= sent;
    ev_bus.now_ms     <= now;
    @(posedge clk);
    while (!ev_bus.ready) @(posedge clk);
    pending_words = {pending_words, predict_event(mode, seq, sent, now)};
  endtask

  task automatic send_ack(logic [SEQ_W-1:0] seq);
    send_event(MODE_ACK, seq, $urandom, $urandom);
  endtask

  task automatic wait_idle();
    ev_bus.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] held;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_LOW_DELAY:  cfg_model.low_delay  = val[DELAY_W-1:0];
      REG_HIGH_DELAY: cfg_model.high_delay = val[DELAY_W-1:0];
      REG_INC_STEP:   cfg_model.inc_step   = val[STEP_W-1:0];
      REG_DEC_STEP:   cfg_model.dec_step   = val[STEP_W-1:0];
      default: ;
    endcase
    held = (idx == REG_LOW_DELAY || idx == REG_HIGH_DELAY) ?
           DATA_W'(val[DELAY_W-1:0]) : DATA_W'(val[STEP_W-1:0]);
    // read back, psel stays high into the read setup
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== held)
      report_mismatch($sformatf("reg %s read %h, want %h", idx.name(), prdata, held));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper bits get junk now and then, the register must drop them
  task automatic set_config(logic [DELAY_W-1:0] low, logic [DELAY_W-1:0] high,
                            logic [STEP_W-1:0] inc, logic [STEP_W-1:0] dec);
    logic [DATA_W-1:0] junk;
    junk = $urandom_range(0, 1) ? $urandom : '0;
    write_reg(REG_LOW_DELAY,  {junk[DATA_W-1:DELAY_W], low});
    write_reg(REG_HIGH_DELAY, {junk[DATA_W-DELAY_W-1:0], high});
    write_reg(REG_INC_STEP,   {junk[DATA_W-STEP_W-1:0], inc});
    write_reg(REG_DEC_STEP,   {junk[DATA_W-1:STEP_W], dec});
  endtask

  always @(posedge clk) begin : check_results
    window_word_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = pending_words.pop_front();
        if (res_bus.window_datagrams !== want.window)
          report_mismatch($sformatf("window %h, want %h",
                                    res_bus.window_datagrams, want.window));
        if (res_bus.table_full !== want.full)
          report_mismatch($sformatf("table_full %b, want %b", res_bus.table_full, want.full));
        if (res_bus.outstanding !== want.outstanding)
          report_mismatch($sformatf("outstanding %0d, want %0d",
                                    res_bus.outstanding, want.outstanding));
      end
    end
  end

  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_stall_en && $urandom_range(0, 7) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
    end
  end

  // reset thresholds: low 20, high 100, steps +1 / -5
  task automatic test_directed_events();
    send_event(MODE_SEND, 32'h0000_0000, 32'd1000, 32'd1005);
    send_event(MODE_SEND, 32'hFFFF_FFFF, 32'd1010, 32'd1010);
    send_event(MODE_SEND, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000);
    send_event(MODE_SEND, 32'h0000_0002, 32'd2000, 32'd1990);
    send_ack(32'h0000_0002);
    send_ack(32'h0BAD_F00D);
    send_event(MODE_SEND, 32'h0000_0000, 32'd1500, 32'd1500);
    send_ack(32'h0000_0000);
    send_ack(32'h0000_0001);
    send_ack(32'hFFFF_FFFF);
    send_event(MODE_SEND, 32'hAAAA_AAAA, 32'h0000_0000, 32'hFFFF_FFFF);
    send_ack(32'hAAAA_AAAA);
    send_event(MODE_SEND, 32'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_ack(32'h5555_5555);
    send_event(MODE_SEND, 32'd10, 32'd5000, 32'd5020);
    send_ack(32'd10);
    send_event(MODE_SEND, 32'd11, 32'd5000, 32'd5021);
    send_ack(32'd11);
    send_event(MODE_SEND, 32'd12, 32'd5000, 32'd5100);
    send_ack(32'd12);
    send_event(MODE_SEND, 32'd13, 32'd5000, 32'd5099);
    send_ack(32'd13);
    wait_idle();
  endtask

  task automatic test_window_floor();
    set_config(16'd20, 16'd0, 8'd0, 8'd255);
    send_event(MODE_SEND, 32'd100, now_base, now_base);
    send_event(MODE_SEND, 32'd101, now_base, now_base);
    send_ack(32'd100);
    wait_idle();
    set_config(16'hFFFF, 16'hFFFF, 8'd255, 8'd0);
    send_ack(32'd101);
    send_event(MODE_SEND, 32'd102, now_base, now_base);
    send_ack(32'd102);
    wait_idle();
  endtask

  task automatic test_full_table();
    logic [SEQ_W-1:0] base;
    int fill;
    base = $urandom;
    fill = TABLE_DEPTH - held_count + 8;
    set_config(16'd0, 16'hFFFF, 8'd1, 8'd1);
    for (int i = 0; i < fill; i++) begin
      now_base += $urandom_range(0, 3);
      send_event(MODE_SEND, base + i, now_base - $urandom_range(0, 2), now_base);
    end
    // duplicate while full frees its own slot first
    send_event(MODE_SEND, pick_live_seq(), now_base, now_base);
    send_ack($urandom);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned n_items;
    int unsigned fill_target;
    int unsigned age_span;
    int unsigned r;
    bit want_send;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          set_config(16'd20, 16'd100, 8'd1, 8'd5);
          n_items = 300; fill_target = 8; age_span = 120;
        end
        1: begin
          set_config(16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
          n_items = 250; fill_target = 40; age_span = 300;
        end
        2: begin
          set_config(16'd0, 16'd0, 8'd0, 8'd0);
          n_items = 150; fill_target = 4; age_span = 10;
        end
        3: begin
          set_config(DELAY_W'($urandom_range(0, 150)), DELAY_W'($urandom_range(0, 300)),
                     STEP_W'($urandom), STEP_W'($urandom));
          n_items = 400; fill_target = 300; age_span = 200;
        end
        default: begin
          set_config(DELAY_W'($urandom_range(0, 150)), DELAY_W'($urandom_range(0, 300)),
                     STEP_W'($urandom), STEP_W'($urandom));
          n_items = (p == 4) ? 250 : 300; fill_target = (p == 4) ? 16 : 8;
          age_span = 200;
        end
      endcase
      if (p == 5) begin
        sender_idle_en    = 1'b0;
        receiver_stall_en = 1'b0;
      end
      for (int unsigned k = 0; k < n_items; k++) begin
        now_base += $urandom_range(0, 40);
        r = $urandom_range(0, 99);
        want_send = (held_count < fill_target) ? (r < 65) : (r < 35);
        if (r < 5) begin
          send_event(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        end else if (r < 12 && held_count > 0) begin
          send_event(MODE_SEND, pick_live_seq(), now_base - $urandom_range(0, age_span),
                     now_base);
        end else if (r < 17) begin
          send_ack($urandom);
        end else if (want_send || held_count == 0) begin
          send_event(MODE_SEND, $urandom, now_base - $urandom_range(0, age_span), now_base);
        end else begin
          send_ack(pick_live_seq());
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    ev_bus.valid       <= 1'b0;
    ev_bus.mode        <= MODE_SEND;
    ev_bus.seq_num     <= '0;
    ev_bus.sent_at_ms  <= '0;
    ev_bus.now_ms      <= '0;
    err_count          = 0;
    cycle_count        = 0;
    sender_idle_en     = 1'b1;
    receiver_stall_en  = 1'b1;
    now_base           = $urandom;
    win_model          = WINDOW_RESET;
    held_count         = 0;
    cfg_model.low_delay  = LOW_RESET;
    cfg_model.high_delay = HIGH_RESET;
    cfg_model.inc_step   = INC_RESET;
    cfg_model.dec_step   = DEC_RESET;
    for (int i = 0; i < TABLE_DEPTH; i++) held_live[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_events();
    test_window_floor();
    test_full_table();
    test_random_traffic();

    repeat (TABLE_DEPTH + 20) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/dwc_pkg.sv
hdl/dwc_in_if.sv
hdl/dwc_out_if.sv
hdl/dwc_cfg_regs.sv
hdl/dwc_entry_mem.sv
hdl/dwc_scan_ctrl.sv
hdl/delay_window_controller.sv
tb/tb_top.sv
